@@ rtl/core/chup_pkg.sv @@
// ----------------------------------------------------------------------------
// chup_pkg
// Shared constants, types and helpers of the 4:2:0 to 4:4:4 chroma upsampler.
// ----------------------------------------------------------------------------
package chup_pkg;

   // plane limits
   localparam int MAX_CHROMA_WIDTH  = 1024;
   localparam int MAX_CHROMA_HEIGHT = 1024;
   localparam int COL_W             = $clog2(MAX_CHROMA_WIDTH);
   localparam int ROW_W             = $clog2(MAX_CHROMA_HEIGHT);

   // field widths
   localparam int CFG_W     = 11;
   localparam int SAMPLE_W  = 8;
   localparam int POS_W     = 10;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_HEIGHT = 1'd1;

   // register reset values
   localparam int DEF_CHROMA_WIDTH  = 360;
   localparam int DEF_CHROMA_HEIGHT = 288;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // bit positions of the emit mask, in emission order
   localparam int EMIT_N          = 4;
   localparam int EMIT_ABOVE_LEFT = 0;  // block (r-1,c-1)
   localparam int EMIT_ABOVE_HERE = 1;  // block (r-1,c), row end
   localparam int EMIT_HERE_LEFT  = 2;  // block (r,c-1), last row
   localparam int EMIT_HERE_HERE  = 3;  // block (r,c), last sample

   // 3x3 sample window, [row][col], row 2 / col 2 newest
   typedef logic [2:0][2:0][SAMPLE_W-1:0] chup_window_type;

   // active plane size, each minus one
   typedef struct packed {
      logic [COL_W-1:0] w_m1;
      logic [ROW_W-1:0] h_m1;
   } chup_dims_type;

   // one input sample's worth of pending blocks
   typedef struct packed {
      chup_window_type   window;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [EMIT_N-1:0] mask;
   } chup_job_type;

   // clamp a written width to 1..max and subtract one
   function automatic logic [COL_W-1:0] clamp_width_m1(input logic [CFG_W-1:0] v);
      logic [COL_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > MAX_CHROMA_WIDTH) begin
         res = COL_W'(MAX_CHROMA_WIDTH - 1);
      end else begin
         res = COL_W'(v - 1'b1);
      end
      return res;
   endfunction

   // clamp a written height to 1..max and subtract one
   function automatic logic [ROW_W-1:0] clamp_height_m1(input logic [CFG_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > MAX_CHROMA_HEIGHT) begin
         res = ROW_W'(MAX_CHROMA_HEIGHT - 1);
      end else begin
         res = ROW_W'(v - 1'b1);
      end
      return res;
   endfunction

   // (diag + 3*(vert+horiz) + 9*centre + 8) >> 4
   function automatic logic [SAMPLE_W-1:0] bilinear_pix(
      input logic [SAMPLE_W-1:0] d,
      input logic [SAMPLE_W-1:0] v,
      input logic [SAMPLE_W-1:0] h,
      input logic [SAMPLE_W-1:0] c
   );
      logic [SAMPLE_W:0]   vh;
      logic [SAMPLE_W+3:0] sum;
      vh  = {1'b0, v} + {1'b0, h};
      sum = (SAMPLE_W+4)'(d) + (SAMPLE_W+4)'(vh) * (SAMPLE_W+4)'(3)
          + (SAMPLE_W+4)'(c) * (SAMPLE_W+4)'(9) + (SAMPLE_W+4)'(8);
      return sum[SAMPLE_W+3:4];
   endfunction

endpackage

@@ rtl/core/chroma_420_to_444_bilinear_upsample_unit.sv @@
// ----------------------------------------------------------------------------
// chroma_420_to_444_bilinear_upsample_unit
// Streaming 4:2:0 to 4:4:4 bilinear chroma upsampler, top level.
// ----------------------------------------------------------------------------
// Takes one chroma sample per beat in raster order and returns 2x2 blocks of
// full-resolution chroma, each pixel (diag + 3*(vert+horiz) + 9*centre + 8)>>4
// with off-plane neighbors replaced by the centre. Sample (r,c) releases block
// (r-1,c-1), plus (r-1,c) at a row end; the last row also releases (r,c-1)
// and, at its end, (r,c). The input takes one sample per cycle; the back end
// emits one block per cycle unless rsp_tready stalls it, so every row after
// the first produces width blocks from width samples and the last row twice
// as many, and once the four-entry job queue fills the input stalls until the
// back end catches up. With an empty queue and a free output, a sample's job
// passes the stage-1 register and the job queue to the output register.
// Any register write restarts the plane at row 0, column 0; width and height
// of 0 act as 1 and values above 1024 act as 1024. rsp_tlast marks the last
// block a sample releases and rsp_tuser marks the final block of the plane.
// ----------------------------------------------------------------------------
module chroma_420_to_444_bilinear_upsample_unit (
   input  logic                                clock,
   input  logic                                reset,
   // sample stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chup_pkg::REQ_DATA_W-1:0]     req_tdata,   // chroma_sample[7:0]
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // block_row[9:0], block_col[19:10], top_left[27:20], top_right[35:28],
   // bottom_left[43:36], bottom_right[51:44], zero fill above
   output logic [chup_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,   // last_of_run
   output logic                                rsp_tuser,   // frame_done
   // configuration
   input  logic                                csr_wr_en,
   input  logic [chup_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chup_pkg::CFG_W-1:0]          csr_wdata
);

   chup_pkg::chup_dims_type        dims;
   logic [chup_pkg::QCNT_W-1:0]    q_count;
   logic                           q_push;
   chup_pkg::chup_job_type         q_job;
   logic                           head_valid;
   chup_pkg::chup_job_type         head_job;
   logic                           pop;

   chup_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .dims       (dims),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_job      (q_job)
   );

   chup_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (q_count)
   );

   chup_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/core/chup_front.sv @@
// ----------------------------------------------------------------------------
// chup_front
// Accepts chroma samples, keeps the plane counters, the two row stores and
// the 3x3 window, and queues a job for every sample that releases blocks.
// ----------------------------------------------------------------------------
module chup_front (
   input  logic                                clock,
   input  logic                                reset,
   // sample stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chup_pkg::REQ_DATA_W-1:0]     req_tdata,   // chroma_sample[7:0]
   // configuration
   input  logic                                csr_wr_en,
   input  logic [chup_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chup_pkg::CFG_W-1:0]          csr_wdata,
   output chup_pkg::chup_dims_type             dims,
   // job queue
   input  logic [chup_pkg::QCNT_W-1:0]         q_count,
   output logic                                q_push,
   output chup_pkg::chup_job_type              q_job
);

   localparam int COL_W    = chup_pkg::COL_W;
   localparam int ROW_W    = chup_pkg::ROW_W;
   localparam int SAMPLE_W = chup_pkg::SAMPLE_W;
   localparam int MEM_W    = 2 * SAMPLE_W;

   // configuration and counters
   chup_pkg::chup_dims_type dims_ff, dims_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        c_cur;
   logic [ROW_W-1:0]        r_cur;
   logic                    accept;

   // stage 1
   logic                    s1_valid_ff;
   logic [SAMPLE_W-1:0]     s1_sample_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic                    s1_fwd_ff, s1_fwd_in;
   logic [MEM_W-1:0]        s1_fwd_data_ff, s1_fwd_data_in;
   logic [MEM_W-1:0]        mem_rd_ff;
   logic [MEM_W-1:0]        rd_eff;

   // row stores: {two rows above, row above} per column
   logic [MEM_W-1:0]        row_mem [chup_pkg::MAX_CHROMA_WIDTH];

   chup_pkg::chup_window_type window_ff, window_in;
   logic [chup_pkg::EMIT_N-1:0] mask;
   logic [chup_pkg::QCNT_W:0]   occ;

   // hold back input while the queue may not take the jobs in flight
   always_comb begin
      occ        = {1'b0, q_count} + (chup_pkg::QCNT_W+1)'(s1_valid_ff);
      req_tready = occ < (chup_pkg::QCNT_W+1)'(chup_pkg::QUEUE_DEPTH);
   end

   assign accept = req_tvalid && req_tready;
   assign dims   = dims_ff;

   // restart the plane if the counters stand beyond the plane
   always_comb begin
      if (col_ff > dims_ff.w_m1 || row_ff > dims_ff.h_m1) begin
         c_cur = '0;
         r_cur = '0;
      end else begin
         c_cur = col_ff;
         r_cur = row_ff;
      end
   end

   // next counters and registers
   always_comb begin
      dims_in = dims_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            chup_pkg::REG_CHROMA_WIDTH:  dims_in.w_m1 = chup_pkg::clamp_width_m1(csr_wdata);
            chup_pkg::REG_CHROMA_HEIGHT: dims_in.h_m1 = chup_pkg::clamp_height_m1(csr_wdata);
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (c_cur == dims_ff.w_m1) begin
            col_in = '0;
            row_in = (r_cur == dims_ff.h_m1) ? '0 : r_cur + 1'b1;
         end else begin
            col_in = c_cur + 1'b1;
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.w_m1 <= chup_pkg::clamp_width_m1(
                            chup_pkg::CFG_W'(chup_pkg::DEF_CHROMA_WIDTH));
         dims_ff.h_m1 <= chup_pkg::clamp_height_m1(
                            chup_pkg::CFG_W'(chup_pkg::DEF_CHROMA_HEIGHT));
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         dims_ff      <= dims_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= accept;
      end
   end

   // forward the store entry written by the sample in stage 1 (width of one)
   assign rd_eff = s1_fwd_ff ? s1_fwd_data_ff : mem_rd_ff;

   always_comb begin
      s1_fwd_in      = s1_valid_ff && (s1_col_ff == c_cur);
      s1_fwd_data_in = {rd_eff[SAMPLE_W-1:0], s1_sample_ff};
   end

   // capture the accepted beat and read its column
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff   <= req_tdata[SAMPLE_W-1:0];
         s1_row_ff      <= r_cur;
         s1_col_ff      <= c_cur;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= s1_fwd_data_in;
         mem_rd_ff      <= row_mem[c_cur];
      end
   end

   // shift the rows down in the store
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         row_mem[s1_col_ff] <= {rd_eff[SAMPLE_W-1:0], s1_sample_ff};
      end
   end

   // slide the window by one column
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         window_in[k][0] = window_ff[k][1];
         window_in[k][1] = window_ff[k][2];
      end
      window_in[0][2] = rd_eff[MEM_W-1:SAMPLE_W];
      window_in[1][2] = rd_eff[SAMPLE_W-1:0];
      window_in[2][2] = s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // classify which blocks this sample releases
   always_comb begin
      mask = '0;
      mask[chup_pkg::EMIT_ABOVE_LEFT] = (s1_row_ff != '0) && (s1_col_ff != '0);
      mask[chup_pkg::EMIT_ABOVE_HERE] = (s1_row_ff != '0) && (s1_col_ff == dims_ff.w_m1);
      mask[chup_pkg::EMIT_HERE_LEFT]  = (s1_row_ff == dims_ff.h_m1) && (s1_col_ff != '0);
      mask[chup_pkg::EMIT_HERE_HERE]  = (s1_row_ff == dims_ff.h_m1)
                                     && (s1_col_ff == dims_ff.w_m1);
   end

   always_comb begin
      q_job.window = window_in;
      q_job.row    = s1_row_ff;
      q_job.col    = s1_col_ff;
      q_job.mask   = mask;
      q_push       = s1_valid_ff && (mask != '0);
   end

endmodule

@@ rtl/core/chup_queue.sv @@
// ----------------------------------------------------------------------------
// chup_queue
// Short job queue that decouples the sample front from the block back end.
// ----------------------------------------------------------------------------
module chup_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  chup_pkg::chup_job_type       push_job,
   input  logic                         pop,
   output logic                         head_valid,
   output chup_pkg::chup_job_type       head_job,
   output logic [chup_pkg::QCNT_W-1:0]  count
);

   localparam int QPTR_W = chup_pkg::QPTR_W;
   localparam int QCNT_W = chup_pkg::QCNT_W;

   chup_pkg::chup_job_type entry_ff [chup_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == chup_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == chup_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   // occupancy checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(count_ff) < chup_pkg::QUEUE_DEPTH))
      else $error("job queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue popped while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count lost a push");

endmodule

@@ rtl/core/chup_back.sv @@
// ----------------------------------------------------------------------------
// chup_back
// Walks the blocks of the head job one per beat, filters each 2x2 block with
// edge replacement and drives the registered result stream.
// ----------------------------------------------------------------------------
module chup_back (
   input  logic                                clock,
   input  logic                                reset,
   input  chup_pkg::chup_dims_type             dims,
   // job queue
   input  logic                                head_valid,
   input  chup_pkg::chup_job_type              head_job,
   output logic                                pop,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // block_row[9:0], block_col[19:10], top_left[27:20], top_right[35:28],
   // bottom_left[43:36], bottom_right[51:44], zero fill above
   output logic [chup_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,   // last_of_run
   output logic                                rsp_tuser    // frame_done
);

   localparam int SAMPLE_W = chup_pkg::SAMPLE_W;
   localparam int POS_W    = chup_pkg::POS_W;
   localparam int EMIT_N   = chup_pkg::EMIT_N;

   logic [EMIT_N-1:0]            done_ff, done_in;
   logic [EMIT_N-1:0]            remaining;
   logic [EMIT_N-1:0]            pick;
   logic                         last;
   logic                         load;
   logic                         row_lo, col_lo;
   logic [1:0]                   rr, cc;
   logic [chup_pkg::ROW_W-1:0]   br;
   logic [chup_pkg::COL_W-1:0]   bc;
   logic                         at_top, at_bottom, at_left, at_right;
   logic [SAMPLE_W-1:0]          ctr;
   logic [2:0][2:0][SAMPLE_W-1:0] nb;
   logic [SAMPLE_W-1:0]          px_tl, px_tr, px_bl, px_br;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]             rsp_row_ff, rsp_col_ff;
   logic [SAMPLE_W-1:0]          rsp_tl_ff, rsp_tr_ff, rsp_bl_ff, rsp_br_ff;
   logic                         rsp_last_ff, rsp_done_ff;

   // pick the first block still owed by the head job
   always_comb begin
      remaining = head_job.mask & ~done_ff;
      pick      = '0;
      priority if (remaining[chup_pkg::EMIT_ABOVE_LEFT]) begin
         pick[chup_pkg::EMIT_ABOVE_LEFT] = 1'b1;
      end else if (remaining[chup_pkg::EMIT_ABOVE_HERE]) begin
         pick[chup_pkg::EMIT_ABOVE_HERE] = 1'b1;
      end else if (remaining[chup_pkg::EMIT_HERE_LEFT]) begin
         pick[chup_pkg::EMIT_HERE_LEFT] = 1'b1;
      end else begin
         pick[chup_pkg::EMIT_HERE_HERE] = 1'b1;
      end
      last = ((remaining & ~pick) == '0);
   end

   // block position and window centre
   always_comb begin
      row_lo = pick[chup_pkg::EMIT_ABOVE_LEFT] || pick[chup_pkg::EMIT_ABOVE_HERE];
      col_lo = pick[chup_pkg::EMIT_ABOVE_LEFT] || pick[chup_pkg::EMIT_HERE_LEFT];
      rr     = row_lo ? 2'd1 : 2'd2;
      cc     = col_lo ? 2'd1 : 2'd2;
      br     = row_lo ? head_job.row - 1'b1 : head_job.row;
      bc     = col_lo ? head_job.col - 1'b1 : head_job.col;
      at_top    = (br == '0);
      at_bottom = (br == dims.h_m1);
      at_left   = (bc == '0);
      at_right  = (bc == dims.w_m1);
      ctr       = head_job.window[rr][cc];
   end

   // gather the 3x3 neighborhood, centre in place of anything off the plane
   always_comb begin
      logic [2:0] wr;
      logic [2:0] wc;
      logic       off;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            wr  = {1'b0, rr} + 3'(i) - 3'd1;
            wc  = {1'b0, cc} + 3'(j) - 3'd1;
            off = (i == 0 && at_top) || (i == 2 && at_bottom)
               || (j == 0 && at_left) || (j == 2 && at_right)
               || (wr > 3'd2) || (wc > 3'd2);
            nb[i][j] = off ? ctr : head_job.window[wr[1:0]][wc[1:0]];
         end
      end
   end

   // filter the four pixels of the block
   always_comb begin
      px_tl = chup_pkg::bilinear_pix(nb[0][0], nb[0][1], nb[1][0], ctr);
      px_tr = chup_pkg::bilinear_pix(nb[0][2], nb[0][1], nb[1][2], ctr);
      px_bl = chup_pkg::bilinear_pix(nb[2][0], nb[2][1], nb[1][0], ctr);
      px_br = chup_pkg::bilinear_pix(nb[2][2], nb[2][1], nb[1][2], ctr);
   end

   // load the output register whenever it is empty or being drained
   always_comb begin
      load         = head_valid && (!rsp_valid_ff || rsp_tready);
      pop          = load && last;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
      if (pop) begin
         done_in = '0;
      end else if (load) begin
         done_in = done_ff | pick;
      end else begin
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff  <= POS_W'(br);
         rsp_col_ff  <= POS_W'(bc);
         rsp_tl_ff   <= px_tl;
         rsp_tr_ff   <= px_tr;
         rsp_bl_ff   <= px_bl;
         rsp_br_ff   <= px_br;
         rsp_last_ff <= last;
         rsp_done_ff <= at_bottom && at_right;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = chup_pkg::RSP_DATA_W'({rsp_br_ff, rsp_bl_ff, rsp_tr_ff, rsp_tl_ff,
                                              rsp_col_ff, rsp_row_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule
